@@ hdl/spa_pkg.sv @@
// shared types, constants and helpers for the saturating pixel arithmetic block
`default_nettype none

package spa_pkg;

  // channel count carried by one request
  localparam int SPA_NCH = 3;

  // quotient bits produced by the divide steps, one per stage
  localparam int SPA_QBITS = 8;

  // lane pipeline depth: setup stage, finish stage, then one stage per quotient bit
  localparam int SPA_DEPTH = SPA_QBITS + 2;

  // datapath widths
  localparam int SPA_SCALAR_W = 18;
  localparam int SPA_NUM_W    = 16;
  localparam int SPA_DEN_W    = 17;
  localparam int SPA_PROD_W   = 25;
  localparam int SPA_SUM_W    = 12;
  localparam int SPA_TRIAL_W  = SPA_DEN_W + SPA_QBITS - 1;

  // configuration register indexes
  localparam int SPA_IDX_W = 1;
  localparam logic [SPA_IDX_W-1:0] SPA_REG_OPERATION = 1'b0;
  localparam logic [SPA_IDX_W-1:0] SPA_REG_SCALAR    = 1'b1;

  typedef enum logic [2:0] {
    SPA_ADD_S = 3'd0,
    SPA_SUB_S = 3'd1,
    SPA_MUL_S = 3'd2,
    SPA_DIV_S = 3'd3,
    SPA_ADD_I = 3'd4,
    SPA_SUB_I = 3'd5,
    SPA_MUL_I = 3'd6,
    SPA_DIV_I = 3'd7
  } op_t;

  // how the finish stage forms the lane result
  typedef enum logic [1:0] {
    SPA_K_DIRECT = 2'd0,
    SPA_K_MULS   = 2'd1,
    SPA_K_MULI   = 2'd2,
    SPA_K_DIV    = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                             op;
    logic signed [SPA_SCALAR_W-1:0] scalar;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            q;
    logic [SPA_PROD_W-1:0] prod;
    logic [SPA_NUM_W-1:0]  num;
    logic [SPA_DEN_W-1:0]  den;
  } setup_t;

  typedef struct packed {
    logic [SPA_QBITS-1:0] q;
    logic                 busy;
    logic [SPA_NUM_W-1:0] rem;
    logic [SPA_DEN_W-1:0] den;
  } divst_t;

  // clamp a signed sum to 0..255
  function automatic logic [7:0] sat8(input logic [SPA_SUM_W-1:0] v);
    logic [7:0] r;
    if (v[SPA_SUM_W-1]) begin
      r = 8'd0;
    end else if (v[SPA_SUM_W-2:8] != '0) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/spa_lane.sv @@
// one channel lane: setup, multiply finish and a pipelined restoring divider
`default_nettype none

module spa_lane (
  input  logic                            clk,
  input  logic [spa_pkg::SPA_DEPTH-1:0]   en,
  input  spa_pkg::cfg_t                   cfg,
  input  logic [7:0]                      a,
  input  logic [7:0]                      b,
  output logic [7:0]                      q
);

  logic [spa_pkg::SPA_SCALAR_W-1:0] mag;
  logic [9:0]                       tmag;
  logic                             s_zero;
  logic                             s_pos;
  logic                             subtract;
  logic                             image;
  logic [spa_pkg::SPA_SUM_W-1:0]    addx;
  logic [spa_pkg::SPA_SUM_W-1:0]    sum;
  logic [spa_pkg::SPA_DEN_W-1:0]    mop;
  logic [spa_pkg::SPA_PROD_W-1:0]   prod;
  spa_pkg::setup_t                  su_nxt;
  spa_pkg::setup_t                  su_r;

  logic [spa_pkg::SPA_DEN_W-1:0]    pm;
  logic [16:0]                      mq;
  logic                             ovf;
  spa_pkg::divst_t                  fin_nxt;

  spa_pkg::divst_t                  st_r    [spa_pkg::SPA_QBITS+1];
  spa_pkg::divst_t                  step_nxt[spa_pkg::SPA_QBITS];
  logic [spa_pkg::SPA_TRIAL_W-1:0]  trial   [spa_pkg::SPA_QBITS];

  // setup: scalar split, shared adder, shared multiplier, divide operands
  always_comb begin
    mag    = cfg.scalar[spa_pkg::SPA_SCALAR_W-1] ?
             spa_pkg::SPA_SCALAR_W'(-cfg.scalar) : spa_pkg::SPA_SCALAR_W'(cfg.scalar);
    tmag   = mag[spa_pkg::SPA_SCALAR_W-1:8];
    s_zero = (cfg.scalar == '0);
    s_pos  = !cfg.scalar[spa_pkg::SPA_SCALAR_W-1] && !s_zero;
    image  = (cfg.op == spa_pkg::SPA_ADD_I) || (cfg.op == spa_pkg::SPA_SUB_I);
    addx   = image ? {4'b0, b} : {2'b0, tmag};
    case (cfg.op)
      spa_pkg::SPA_ADD_S: subtract = cfg.scalar[spa_pkg::SPA_SCALAR_W-1];
      spa_pkg::SPA_SUB_S: subtract = !cfg.scalar[spa_pkg::SPA_SCALAR_W-1];
      spa_pkg::SPA_SUB_I: subtract = 1'b1;
      default:            subtract = 1'b0;
    endcase
    sum  = subtract ? ({4'b0, a} - addx) : ({4'b0, a} + addx);
    mop  = (cfg.op == spa_pkg::SPA_MUL_S) ? cfg.scalar[spa_pkg::SPA_DEN_W-1:0] : {9'b0, b};
    prod = {17'b0, a} * {8'b0, mop};

    su_nxt.kind = spa_pkg::SPA_K_DIRECT;
    su_nxt.q    = spa_pkg::sat8(sum);
    su_nxt.prod = prod;
    su_nxt.num  = {a, 8'b0};
    su_nxt.den  = {9'b0, b};
    case (cfg.op)
      spa_pkg::SPA_MUL_S: begin
        if (s_pos) su_nxt.kind = spa_pkg::SPA_K_MULS;
        else su_nxt.q = 8'd0;
      end
      spa_pkg::SPA_DIV_S: begin
        su_nxt.den = cfg.scalar[spa_pkg::SPA_DEN_W-1:0];
        // zero scalar passes pixel a through, negative scalar clamps to zero
        if (s_zero) su_nxt.q = a;
        else if (s_pos) su_nxt.kind = spa_pkg::SPA_K_DIV;
        else su_nxt.q = 8'd0;
      end
      spa_pkg::SPA_MUL_I: su_nxt.kind = spa_pkg::SPA_K_MULI;
      spa_pkg::SPA_DIV_I: begin
        su_nxt.num = {a, 8'b0} - {8'b0, a};
        if (b == 8'd0) su_nxt.q = 8'hFF;
        else su_nxt.kind = spa_pkg::SPA_K_DIV;
      end
      default: ;
    endcase
  end

  // finish: scale products, divide by 255, check quotient overflow
  always_comb begin
    pm  = su_r.prod[spa_pkg::SPA_PROD_W-1:8];
    mq  = {1'b0, su_r.prod[15:0]} + {9'b0, su_r.prod[15:8]} + 17'd1;
    ovf = ({su_r.den, 8'b0} <= {9'b0, su_r.num});
    fin_nxt.q    = su_r.q;
    fin_nxt.busy = 1'b0;
    fin_nxt.rem  = su_r.num;
    fin_nxt.den  = su_r.den;
    case (su_r.kind)
      spa_pkg::SPA_K_MULS: fin_nxt.q = (pm > 17'd255) ? 8'hFF : pm[7:0];
      spa_pkg::SPA_K_MULI: fin_nxt.q = mq[15:8];
      spa_pkg::SPA_K_DIV: begin
        if (ovf) begin
          fin_nxt.q = 8'hFF;
        end else begin
          fin_nxt.q    = 8'd0;
          fin_nxt.busy = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // divide steps: each stage settles one quotient bit, msb first
  always_comb begin
    for (int k = 0; k < spa_pkg::SPA_QBITS; k++) begin
      trial[k]    = spa_pkg::SPA_TRIAL_W'(st_r[k].den) << (spa_pkg::SPA_QBITS - 1 - k);
      step_nxt[k] = st_r[k];
      if (st_r[k].busy && (trial[k] <= spa_pkg::SPA_TRIAL_W'(st_r[k].rem))) begin
        step_nxt[k].rem = spa_pkg::SPA_NUM_W'(spa_pkg::SPA_TRIAL_W'(st_r[k].rem) - trial[k]);
        step_nxt[k].q[spa_pkg::SPA_QBITS - 1 - k] = 1'b1;
      end
    end
  end

  // stage registers, each advanced by its own enable
  always_ff @(posedge clk) begin
    if (en[0]) su_r <= su_nxt;
    if (en[1]) st_r[0] <= fin_nxt;
    for (int k = 0; k < spa_pkg::SPA_QBITS; k++) begin
      if (en[k+2]) st_r[k+1] <= step_nxt[k];
    end
  end

  assign q = st_r[spa_pkg::SPA_QBITS].q;

endmodule

`default_nettype wire

@@ hdl/saturating_pixel_arithmetic.sv @@
// Saturating per-pixel arithmetic on RGB888, one request per clock while in_stall is low.
// Input channel: in_valid/in_stall with pixel A and pixel B channels.
// Output channel: out_valid/out_stall with three clamped channels and the
// zero scalar error flag. Configuration: cfg_we, cfg_index, cfg_data write
// the operation (index 0) and the Q9.8 scalar (index 1); write only while
// no request is in flight.
// Path: an accepted request passes a setup stage, a finish stage and eight
// divide stages (one quotient bit each) before the output register, which
// raises out_valid. Throughput is one request per cycle while in_stall is
// low: the divider is unrolled into one stage per quotient bit, so every
// stage can take a new request each clock.
// LANES channel lanes run side by side; channels at or above LANES read 0.
// The pipeline collapses bubbles, so requests keep being taken while a result
// waits on out_stall until every stage holds a request.
// Reset (rst_n low, synchronous) empties the pipeline and clears the
// operation and scalar registers to zero.
`default_nettype none

module saturating_pixel_arithmetic #(
  parameter int LANES = 3
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_first_ch0,
  input  logic [7:0]  in_first_ch1,
  input  logic [7:0]  in_first_ch2,
  input  logic [7:0]  in_second_ch0,
  input  logic [7:0]  in_second_ch1,
  input  logic [7:0]  in_second_ch2,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic        out_zero_scalar_error,

  input  logic                                  cfg_we,
  input  logic [spa_pkg::SPA_IDX_W-1:0]         cfg_index,
  input  logic [spa_pkg::SPA_SCALAR_W-1:0]      cfg_data
);

  localparam int Last = spa_pkg::SPA_DEPTH - 1;

  spa_pkg::op_t                      operation_r;
  logic [spa_pkg::SPA_SCALAR_W-1:0]  scalar_r;
  spa_pkg::cfg_t                     cfg;

  logic [spa_pkg::SPA_DEPTH-1:0]     v_r;
  logic [spa_pkg::SPA_DEPTH-1:0]     v_nxt;
  logic [spa_pkg::SPA_DEPTH-1:0]     e_r;
  logic [spa_pkg::SPA_DEPTH-1:0]     go;
  logic                              out_go;
  logic                              err_in;

  logic [7:0]                        a_in  [spa_pkg::SPA_NCH];
  logic [7:0]                        b_in  [spa_pkg::SPA_NCH];
  logic [7:0]                        lane_q[spa_pkg::SPA_NCH];

  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [7:0]                        ch_r  [spa_pkg::SPA_NCH];
  logic                              err_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r <= spa_pkg::SPA_ADD_S;
      scalar_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spa_pkg::SPA_REG_OPERATION: operation_r <= spa_pkg::op_t'(cfg_data[2:0]);
        spa_pkg::SPA_REG_SCALAR:    scalar_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.op     = operation_r;
  assign cfg.scalar = $signed(scalar_r);
  assign err_in     = (operation_r == spa_pkg::SPA_DIV_S) && (scalar_r == '0);

  assign a_in[0] = in_first_ch0;
  assign a_in[1] = in_first_ch1;
  assign a_in[2] = in_first_ch2;
  assign b_in[0] = in_second_ch0;
  assign b_in[1] = in_second_ch1;
  assign b_in[2] = in_second_ch2;

  // stage enables: a stage loads when empty or when its contents move on
  always_comb begin
    out_go   = !out_valid_r || !out_stall;
    go[Last] = !v_r[Last] || out_go;
    for (int k = Last - 1; k >= 0; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
    v_nxt[0] = go[0] ? in_valid : v_r[0];
    for (int k = 1; k < spa_pkg::SPA_DEPTH; k++) begin
      v_nxt[k] = go[k] ? v_r[k-1] : v_r[k];
    end
    out_valid_nxt = out_go ? v_r[Last] : out_valid_r;
  end

  assign in_stall = !go[0];

  // valid bits per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // error flag travels alongside the lanes
  always_ff @(posedge clk) begin
    if (go[0]) e_r[0] <= err_in;
    for (int k = 1; k < spa_pkg::SPA_DEPTH; k++) begin
      if (go[k]) e_r[k] <= e_r[k-1];
    end
  end

  // channel lanes
  for (genvar l = 0; l < spa_pkg::SPA_NCH; l++) begin : g_lane
    if (l < LANES) begin : g_on
      spa_lane u_lane (
        .clk (clk),
        .en  (go),
        .cfg (cfg),
        .a   (a_in[l]),
        .b   (b_in[l]),
        .q   (lane_q[l])
      );
    end else begin : g_off
      assign lane_q[l] = 8'd0;
    end
  end

  // merge lanes and flag into the output register
  always_ff @(posedge clk) begin
    if (out_go && v_r[Last]) begin
      for (int l = 0; l < spa_pkg::SPA_NCH; l++) begin
        ch_r[l] <= lane_q[l];
      end
      err_r <= e_r[Last];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ch0               = ch_r[0];
  assign out_ch1               = ch_r[1];
  assign out_ch2               = ch_r[2];
  assign out_zero_scalar_error = err_r;

  // output register only fills from a valid last stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[Last]))
    else $error("output went valid without a request in the last stage");

  // input is held off only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // an accepted request always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request lost at the first stage");

endmodule

`default_nettype wire
